@@ design/wrh_pkg.sv @@
// Shared types and constants for the WAV RIFF header parser.
// No dependencies; used by wav_riff_header_parser.
package wrh_pkg;

   // Default width of the byte position counter
   localparam int unsigned WRH_LENGTH_BITS = 20;

   // Widths of the result fields
   localparam int unsigned WRH_OFFSET_BITS = 20;

   // Reset value of the expected sample rate register
   localparam logic [31:0] WRH_RATE_RESET = 32'd24000;

   // Chunk and file tags, first byte in the high bits
   localparam logic [31:0] WRH_TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] WRH_TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] WRH_TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] WRH_TAG_DATA = 32'h6461_7461;

   // Smallest accepted fmt payload and offset of bits per sample in it
   localparam logic [31:0] WRH_FMT_MIN_SIZE = 32'd16;
   localparam logic [31:0] WRH_BITS_AT      = 32'd14;

   // Required format values
   localparam logic [15:0] WRH_FORMAT_PCM = 16'd1;
   localparam logic [15:0] WRH_MONO       = 16'd1;
   localparam logic [15:0] WRH_BITS_16    = 16'd16;

   // Parse phases
   typedef enum logic [2:0] {
      PH_RIFF  = 3'd0,
      PH_RSIZE = 3'd1,
      PH_WAVE  = 3'd2,
      PH_HDR   = 3'd3,
      PH_FMT   = 3'd4,
      PH_DATA  = 3'd5,
      PH_OTHER = 3'd6,
      PH_PAD   = 3'd7
   } phase_type;

   // Parser status flags
   typedef struct packed {
      logic failed;
      logic data_seen;
      logic fmt_seen;
   } status_type;

endpackage

@@ design/wav_riff_header_parser.sv @@
// WAV RIFF header parser: walks a byte stream and reports format fields.
// Depends on wrh_pkg for tags, phase type and status flags.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: data_byte; tlast: last
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser: valid_res; tdata: fmt fields
//  csr     | in  | csr_valid/csr_ready    | csr_data: expected_rate
//
// One byte per clock sustained, unless a final byte waits for the result register. An
// accepted request is held in the input register and parsed out of it; parsing a
// final byte also loads the result register with the result of that byte. The input
// register holds a final byte only while the result register is full and
// stalled; other bytes never wait. Synchronous reset clears all parser state
// and sets the expected rate to 24000.
module wav_riff_header_parser #(
   parameter int unsigned LENGTH_BITS = wrh_pkg::WRH_LENGTH_BITS
) (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tlast,
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // [15:0] audio_format, [31:16] channel_count,
                                      // [47:32] sample_bits, [79:48] fmt_rate,
                                      // [99:80] payload_offset, [119:100] payload_bytes
   output logic [0:0]    rsp_tuser,   // [0] valid_res
   // expected rate register
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [31:0]   csr_data
);

   localparam int unsigned OB = wrh_pkg::WRH_OFFSET_BITS;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;

   // configuration
   logic [31:0]            rate_cfg_ff;

   // parser state
   logic [LENGTH_BITS-1:0] pos_ff, pos_in, pos_nx;
   wrh_pkg::phase_type     phase_ff, phase_in, phase_nx;
   logic [31:0]            tag_ff, tag_in, tag_nx;
   logic [31:0]            len_ff, len_in, len_nx;
   logic [31:0]            brem_ff, brem_in, brem_nx;
   logic [15:0]            fmt_ff, fmt_in, fmt_nx;
   logic [15:0]            chan_ff, chan_in, chan_nx;
   logic [15:0]            bits_ff, bits_in, bits_nx;
   logic [31:0]            srate_ff, srate_in, srate_nx;
   logic [OB-1:0]          pstart_ff, pstart_in, pstart_nx;
   logic [OB-1:0]          plen_ff, plen_in, plen_nx;
   wrh_pkg::status_type    status_ff, status_in, status_nx;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [119:0]           rsp_data_ff;
   logic                   rsp_ok_ff;

   // datapath helpers
   logic                   advance;
   logic                   pos_full;
   logic                   take;
   logic [31:0]            brem_inc, brem_dec;
   logic [31:0]            fmt_idx;
   logic [31:0]            pos_wide;
   logic                   hdr_tag_byte;
   logic                   tag_done;
   logic                   chunk_open;
   logic                   is_fmt, is_data;
   logic                   end_fail;
   logic                   result_ok;
   logic [119:0]           result_data;

   // Handshakes: a final byte waits only for a free result register
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // Decide whether this byte is parsed
   assign pos_full = &pos_ff;
   assign take     = !status_ff.failed && !pos_full;
   assign pos_nx   = take ? pos_ff + LENGTH_BITS'(1) : pos_ff;
   assign pos_wide = 32'(pos_nx);

   assign brem_inc     = brem_ff + 32'd1;
   assign brem_dec     = brem_ff - 32'd1;
   assign fmt_idx      = len_ff - brem_ff;
   assign hdr_tag_byte = (brem_ff < 32'd4);

   // Shift tag and size bytes
   always_comb begin
      tag_nx = tag_ff;
      len_nx = len_ff;
      if (take) begin
         if (phase_ff inside {wrh_pkg::PH_RIFF, wrh_pkg::PH_WAVE} ||
             (phase_ff == wrh_pkg::PH_HDR && hdr_tag_byte)) begin
            tag_nx = {tag_ff[23:0], in_byte_ff};
         end else if (phase_ff == wrh_pkg::PH_HDR) begin
            len_nx = {in_byte_ff, len_ff[31:8]};
         end
      end
   end

   assign is_fmt     = (tag_nx == wrh_pkg::WRH_TAG_FMT);
   assign is_data    = (tag_nx == wrh_pkg::WRH_TAG_DATA);
   assign tag_done   = take && (phase_ff inside {wrh_pkg::PH_RIFF, wrh_pkg::PH_WAVE}) &&
                       (brem_inc == 32'd4);
   assign chunk_open = take && (phase_ff == wrh_pkg::PH_HDR) && (brem_inc >= 32'd8);

   // Next parse phase
   always_comb begin
      phase_nx = phase_ff;
      if (take) begin
         case (phase_ff)
            wrh_pkg::PH_RIFF: begin
               if (brem_inc == 32'd4) phase_nx = wrh_pkg::PH_RSIZE;
            end
            wrh_pkg::PH_RSIZE: begin
               if (brem_inc == 32'd4) phase_nx = wrh_pkg::PH_WAVE;
            end
            wrh_pkg::PH_WAVE: begin
               if (brem_inc == 32'd4) phase_nx = wrh_pkg::PH_HDR;
            end
            wrh_pkg::PH_HDR: begin
               if (chunk_open) begin
                  if (len_nx == 32'd0) phase_nx = wrh_pkg::PH_HDR;
                  else if (is_fmt)     phase_nx = wrh_pkg::PH_FMT;
                  else if (is_data)    phase_nx = wrh_pkg::PH_DATA;
                  else                 phase_nx = wrh_pkg::PH_OTHER;
               end
            end
            wrh_pkg::PH_FMT, wrh_pkg::PH_DATA, wrh_pkg::PH_OTHER: begin
               if (brem_dec == 32'd0) begin
                  phase_nx = len_ff[0] ? wrh_pkg::PH_PAD : wrh_pkg::PH_HDR;
               end
            end
            default: phase_nx = wrh_pkg::PH_HDR;
         endcase
      end
   end

   // Byte counter within a phase
   always_comb begin
      brem_nx = brem_ff;
      if (take) begin
         case (phase_ff)
            wrh_pkg::PH_RIFF, wrh_pkg::PH_RSIZE, wrh_pkg::PH_WAVE: begin
               brem_nx = (brem_inc == 32'd4) ? 32'd0 : brem_inc;
            end
            wrh_pkg::PH_HDR: begin
               brem_nx = chunk_open ? len_nx : brem_inc;
            end
            wrh_pkg::PH_FMT, wrh_pkg::PH_DATA, wrh_pkg::PH_OTHER: begin
               brem_nx = brem_dec;
            end
            default: brem_nx = 32'd0;
         endcase
      end
   end

   // Status flags and data chunk capture
   always_comb begin
      status_nx = status_ff;
      pstart_nx = pstart_ff;
      plen_nx   = plen_ff;
      if (!status_ff.failed && pos_full) status_nx.failed = 1'b1;
      if (tag_done) begin
         if (phase_ff == wrh_pkg::PH_RIFF && tag_nx != wrh_pkg::WRH_TAG_RIFF)
            status_nx.failed = 1'b1;
         if (phase_ff == wrh_pkg::PH_WAVE && tag_nx != wrh_pkg::WRH_TAG_WAVE)
            status_nx.failed = 1'b1;
      end
      if (chunk_open) begin
         if (is_fmt) begin
            if (len_nx < wrh_pkg::WRH_FMT_MIN_SIZE) status_nx.failed = 1'b1;
            else                                    status_nx.fmt_seen = 1'b1;
         end else if (is_data) begin
            pstart_nx           = pos_wide[OB-1:0];
            plen_nx             = len_nx[OB-1:0];
            status_nx.data_seen = 1'b1;
         end
      end
   end

   // Capture fmt payload fields
   always_comb begin
      fmt_nx   = fmt_ff;
      chan_nx  = chan_ff;
      bits_nx  = bits_ff;
      srate_nx = srate_ff;
      if (take && phase_ff == wrh_pkg::PH_FMT) begin
         if (fmt_idx < 32'd2) begin
            if (fmt_idx[0]) fmt_nx[15:8] = in_byte_ff;
            else            fmt_nx[7:0]  = in_byte_ff;
         end else if (fmt_idx < 32'd4) begin
            if (fmt_idx[0]) chan_nx[15:8] = in_byte_ff;
            else            chan_nx[7:0]  = in_byte_ff;
         end else if (fmt_idx < 32'd8) begin
            srate_nx[8*fmt_idx[1:0] +: 8] = in_byte_ff;
         end else if (fmt_idx == wrh_pkg::WRH_BITS_AT ||
                      fmt_idx == wrh_pkg::WRH_BITS_AT + 32'd1) begin
            if (fmt_idx[0]) bits_nx[15:8] = in_byte_ff;
            else            bits_nx[7:0]  = in_byte_ff;
         end
      end
   end

   // Final checks on the last byte
   assign end_fail = (phase_nx inside {wrh_pkg::PH_RIFF, wrh_pkg::PH_RSIZE, wrh_pkg::PH_WAVE,
                                       wrh_pkg::PH_FMT, wrh_pkg::PH_DATA, wrh_pkg::PH_OTHER}) ||
                     (phase_nx == wrh_pkg::PH_PAD && !is_data);

   assign result_ok = !status_nx.failed && !end_fail &&
                      status_nx.fmt_seen && status_nx.data_seen &&
                      fmt_nx == wrh_pkg::WRH_FORMAT_PCM &&
                      chan_nx == wrh_pkg::WRH_MONO &&
                      bits_nx == wrh_pkg::WRH_BITS_16 &&
                      srate_nx == rate_cfg_ff && !plen_nx[0];

   assign result_data = {plen_nx, pstart_nx, srate_nx, bits_nx, chan_nx, fmt_nx};

   // Advance parser state; return to reset after the last byte
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      brem_in   = brem_ff;
      fmt_in    = fmt_ff;
      chan_in   = chan_ff;
      bits_in   = bits_ff;
      srate_in  = srate_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      status_in = status_ff;
      if (advance) begin
         if (in_last_ff) begin
            pos_in    = '0;
            phase_in  = wrh_pkg::PH_RIFF;
            tag_in    = '0;
            len_in    = '0;
            brem_in   = '0;
            fmt_in    = '0;
            chan_in   = '0;
            bits_in   = '0;
            srate_in  = '0;
            pstart_in = '0;
            plen_in   = '0;
            status_in = '0;
         end else begin
            pos_in    = pos_nx;
            phase_in  = phase_nx;
            tag_in    = tag_nx;
            len_in    = len_nx;
            brem_in   = brem_nx;
            fmt_in    = fmt_nx;
            chan_in   = chan_nx;
            bits_in   = bits_nx;
            srate_in  = srate_nx;
            pstart_in = pstart_nx;
            plen_in   = plen_nx;
            status_in = status_nx;
         end
      end
   end

   // Valid flags of the two register stages
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready)       rsp_valid_in = 1'b0;
   end

   // Control and parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_cfg_ff  <= wrh_pkg::WRH_RATE_RESET;
         pos_ff       <= '0;
         phase_ff     <= wrh_pkg::PH_RIFF;
         tag_ff       <= '0;
         len_ff       <= '0;
         brem_ff      <= '0;
         fmt_ff       <= '0;
         chan_ff      <= '0;
         bits_ff      <= '0;
         srate_ff     <= '0;
         pstart_ff    <= '0;
         plen_ff      <= '0;
         status_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) rate_cfg_ff <= csr_data;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         brem_ff      <= brem_in;
         fmt_ff       <= fmt_in;
         chan_ff      <= chan_in;
         bits_ff      <= bits_in;
         srate_ff     <= srate_in;
         pstart_ff    <= pstart_in;
         plen_ff      <= plen_in;
         status_ff    <= status_in;
      end
   end

   // Payload registers: hold the request byte and the result
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= result_data;
         rsp_ok_ff   <= result_ok;
      end
   end

endmodule
